@@ hw/rtl/lcm_pkg.sv @@
// Package for the linear crossfade mixer: constants, register indexes, FSM states
// and the command/status structs shared by the controller and the datapath.
// No dependencies.
package lcm_pkg;

   // Default width of the fade position counter.
   localparam int INDEX_WIDTH_DEFAULT = 24;

   // Fixed field widths.
   localparam int SAMPLE_W  = 16;
   localparam int LENGTH_W  = 24;
   localparam int SCALED_W  = 17;
   localparam int PRODUCT_W = 26;

   // Gain arithmetic: gains lie in 0..256 and take nine quotient bits.
   localparam int GAIN_W      = 9;
   localparam int GAIN_SHIFT  = 8;
   localparam int ROUND_HALF  = 128;
   localparam int DIV_STEPS   = 9;
   localparam int DIV_CNT_W   = 4;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;
   localparam logic [CSR_INDEX_W-1:0] REG_SAMPLE_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MIX_LENGTH  = 2'd1;

   // Sample modes.
   localparam logic MODE_BYTE_AVERAGE = 1'b0;
   localparam logic MODE_WORD_SUM     = 1'b1;

   // Reset values of the registers.
   localparam logic                MODE_RESET   = MODE_WORD_SUM;
   localparam logic [LENGTH_W-1:0] LENGTH_RESET = 24'd1;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RISE_INIT,
      ST_RISE_DIV,
      ST_FALL_INIT,
      ST_FALL_DIV,
      ST_MUL_RISE,
      ST_MUL_FALL,
      ST_SCALE,
      ST_MIX
   } ctl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // capture a new transaction
      logic div_init;    // load the divider with a dividend and divisor
      logic div_fall;    // divider works on the fade-out gain
      logic div_step;    // one restoring division step
      logic gain_save;   // store the finished quotient as a gain
      logic mul_rise;    // multiply the rising sample by its gain
      logic mul_fall;    // scale the rising product, multiply the falling one
      logic scale_fall;  // scale the falling product
      logic mix;         // combine, load the result and advance the index
   } lcm_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_last;    // the divider is on its final step
   } lcm_status_type;

endpackage

@@ hw/rtl/lcm_ctrl.sv @@
// Controller of the linear crossfade mixer: sequences one transaction through the
// gain divider, the multiplier and the mix stage. Depends on lcm_pkg.
module lcm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  lcm_pkg::lcm_status_type status,
   output lcm_pkg::lcm_cmd_type    cmd
);

   lcm_pkg::ctl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   // The result register can take a new value when empty or being drained.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != lcm_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lcm_pkg::ST_IDLE: begin
            if (req_valid) state_in = lcm_pkg::ST_RISE_INIT;
         end
         lcm_pkg::ST_RISE_INIT: state_in = lcm_pkg::ST_RISE_DIV;
         lcm_pkg::ST_RISE_DIV: begin
            if (status.div_last) state_in = lcm_pkg::ST_FALL_INIT;
         end
         lcm_pkg::ST_FALL_INIT: state_in = lcm_pkg::ST_FALL_DIV;
         lcm_pkg::ST_FALL_DIV: begin
            if (status.div_last) state_in = lcm_pkg::ST_MUL_RISE;
         end
         lcm_pkg::ST_MUL_RISE: state_in = lcm_pkg::ST_MUL_FALL;
         lcm_pkg::ST_MUL_FALL: state_in = lcm_pkg::ST_SCALE;
         lcm_pkg::ST_SCALE:    state_in = lcm_pkg::ST_MIX;
         lcm_pkg::ST_MIX: begin
            if (out_free) state_in = lcm_pkg::ST_IDLE;
         end
         default: state_in = lcm_pkg::ST_IDLE;
      endcase
   end

   // Commands and the result valid flag.
   always_comb begin
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         lcm_pkg::ST_IDLE:      cmd.load = req_valid;
         lcm_pkg::ST_RISE_INIT: cmd.div_init = 1'b1;
         lcm_pkg::ST_RISE_DIV: begin
            cmd.div_step  = 1'b1;
            cmd.gain_save = status.div_last;
         end
         lcm_pkg::ST_FALL_INIT: begin
            cmd.div_init = 1'b1;
            cmd.div_fall = 1'b1;
         end
         lcm_pkg::ST_FALL_DIV: begin
            cmd.div_fall  = 1'b1;
            cmd.div_step  = 1'b1;
            cmd.gain_save = status.div_last;
         end
         lcm_pkg::ST_MUL_RISE: cmd.mul_rise = 1'b1;
         lcm_pkg::ST_MUL_FALL: cmd.mul_fall = 1'b1;
         lcm_pkg::ST_SCALE:    cmd.scale_fall = 1'b1;
         lcm_pkg::ST_MIX: begin
            if (out_free) begin
               cmd.mix      = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: cmd = '0;
      endcase
   end

   // State and valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A new transaction is taken only from idle, so the block is busy right after it.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("controller accepted a transaction and did not go busy");

   // A result is never loaded over one that is still stalled.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.mix |-> !(rsp_valid && rsp_stall))
      else $error("result register overwritten while stalled");

   // A stalled result stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result withdrawn while stalled");

endmodule

@@ hw/rtl/lcm_datapath.sv @@
// Datapath of the linear crossfade mixer: configuration registers, fade index,
// serial gain divider, shared multiplier, mix and result register. Depends on lcm_pkg.
module lcm_datapath #(
   parameter int INDEX_WIDTH = lcm_pkg::INDEX_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [lcm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [lcm_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic signed [lcm_pkg::SAMPLE_W-1:0]  req_rising_sample,
   input  logic signed [lcm_pkg::SAMPLE_W-1:0]  req_falling_sample,
   output logic signed [lcm_pkg::SAMPLE_W-1:0]  rsp_mixed_sample,
   output logic                                 rsp_last_of_fade,
   input  lcm_pkg::lcm_cmd_type                 cmd,
   output lcm_pkg::lcm_status_type              status
);

   localparam int NW     = INDEX_WIDTH + 1;
   localparam int CALC_W = (NW > lcm_pkg::LENGTH_W) ? NW : lcm_pkg::LENGTH_W;
   localparam int RW     = INDEX_WIDTH + 11;
   localparam int SW     = lcm_pkg::SAMPLE_W;

   // Floor of (product + 128) / 256, kept to the scaled width.
   function automatic logic signed [lcm_pkg::SCALED_W-1:0] scale_product(
      input logic signed [lcm_pkg::PRODUCT_W-1:0] p);
      logic signed [lcm_pkg::PRODUCT_W-1:0] shifted;
      shifted = (p + lcm_pkg::PRODUCT_W'(lcm_pkg::ROUND_HALF)) >>> lcm_pkg::GAIN_SHIFT;
      return shifted[lcm_pkg::SCALED_W-1:0];
   endfunction

   // Configuration and fade position.
   logic                          mode_ff;
   logic [lcm_pkg::LENGTH_W-1:0]  length_ff;
   logic [INDEX_WIDTH-1:0]        fade_index_ff, fade_index_in;

   // Per-transaction operands.
   logic [NW-1:0]                 n_ff, n_in;
   logic [INDEX_WIDTH-1:0]        k_ff, k_in;
   logic                          last_ff, last_in;
   logic signed [SW-1:0]          s_rise_ff, s_fall_ff, s_rise_in, s_fall_in;

   // Divider.
   logic [RW-1:0]                 rem_ff, rem_in, dvs_ff, dvs_in;
   logic [RW-1:0]                 dividend_rise, dividend_fall;
   logic [lcm_pkg::GAIN_W-1:0]    q_ff, q_in;
   logic [lcm_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          q_bit;
   logic [lcm_pkg::GAIN_W-1:0]    g_rise_ff, g_fall_ff;

   // Multiplier and mix.
   logic signed [lcm_pkg::PRODUCT_W-1:0] prod_ff, prod_in;
   logic signed [SW-1:0]                 mul_s;
   logic [lcm_pkg::GAIN_W-1:0]           mul_g;
   logic signed [lcm_pkg::SCALED_W-1:0]  a_ff, b_ff;
   logic signed [lcm_pkg::SCALED_W:0]    sum;
   logic signed [lcm_pkg::SCALED_W:0]    half;
   logic signed [SW-1:0]                 mixed_in, mixed_ff;
   logic                                 last_out_ff;

   // Clamp the length to 1..2^INDEX_WIDTH and the index below the length.
   logic [CALC_W-1:0] len_ext;
   logic [CALC_W-1:0] len_limit;
   logic [CALC_W-1:0] n_calc;
   logic [NW-1:0]     n_minus_one;
   always_comb begin
      len_ext   = CALC_W'(length_ff);
      len_limit = CALC_W'(1) << INDEX_WIDTH;
      if (len_ext == '0) begin
         n_calc = CALC_W'(1);
      end else if (len_ext > len_limit) begin
         n_calc = len_limit;
      end else begin
         n_calc = len_ext;
      end
      n_in        = n_calc[NW-1:0];
      n_minus_one = n_in - NW'(1);
      if ({1'b0, fade_index_ff} >= n_in) begin
         k_in = n_minus_one[INDEX_WIDTH-1:0];
      end else begin
         k_in = fade_index_ff;
      end
      last_in = ({1'b0, k_in} == n_minus_one);
   end

   // In byte mode only the low byte of each sample counts, read as signed.
   always_comb begin
      if (mode_ff == lcm_pkg::MODE_BYTE_AVERAGE) begin
         s_rise_in = SW'($signed(req_rising_sample[7:0]));
         s_fall_in = SW'($signed(req_falling_sample[7:0]));
      end else begin
         s_rise_in = req_rising_sample;
         s_fall_in = req_falling_sample;
      end
   end

   // Gain = (512*num + n) / (2*n), with num = k or n - k.
   logic [NW-1:0] n_minus_k;
   always_comb begin
      n_minus_k     = n_ff - {1'b0, k_ff};
      dividend_rise = (RW'(k_ff) << lcm_pkg::GAIN_W) + RW'(n_ff);
      dividend_fall = (RW'(n_minus_k) << lcm_pkg::GAIN_W) + RW'(n_ff);
   end

   // Restoring division, one quotient bit per step from the top.
   always_comb begin
      q_bit  = (rem_ff >= dvs_ff);
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      q_in   = {q_ff[lcm_pkg::GAIN_W-2:0], q_bit};
      cnt_in = cnt_ff;
      if (cmd.div_init) begin
         rem_in = cmd.div_fall ? dividend_fall : dividend_rise;
         dvs_in = RW'(n_ff) << lcm_pkg::GAIN_W;
         cnt_in = '0;
      end else if (cmd.div_step) begin
         if (q_bit) rem_in = rem_ff - dvs_ff;
         dvs_in = dvs_ff >> 1;
         cnt_in = cnt_ff + lcm_pkg::DIV_CNT_W'(1);
      end
   end

   assign status.div_last = (cnt_ff == lcm_pkg::DIV_CNT_W'(lcm_pkg::DIV_STEPS - 1));

   // One shared multiplier: rising sample first, falling sample next.
   always_comb begin
      mul_s   = cmd.mul_fall ? s_fall_ff : s_rise_ff;
      mul_g   = cmd.mul_fall ? g_fall_ff : g_rise_ff;
      prod_in = $signed({{(lcm_pkg::PRODUCT_W - SW){mul_s[SW-1]}}, mul_s})
              * $signed({{(lcm_pkg::PRODUCT_W - lcm_pkg::GAIN_W){1'b0}}, mul_g});
   end

   // Average toward zero in byte mode, saturating sum in word mode.
   always_comb begin
      sum  = {a_ff[lcm_pkg::SCALED_W-1], a_ff} + {b_ff[lcm_pkg::SCALED_W-1], b_ff};
      half = sum[lcm_pkg::SCALED_W] ? ((sum + (lcm_pkg::SCALED_W + 1)'(1)) >>> 1)
                                    : (sum >>> 1);
      if (mode_ff == lcm_pkg::MODE_BYTE_AVERAGE) begin
         mixed_in = half[SW-1:0];
      end else if (sum > 18'sd32767) begin
         mixed_in = 16'sh7FFF;
      end else if (sum < -18'sd32768) begin
         mixed_in = 16'sh8000;
      end else begin
         mixed_in = sum[SW-1:0];
      end
   end

   // The index wraps to zero after the final pair of the fade.
   assign fade_index_in = last_ff ? '0 : (k_ff + INDEX_WIDTH'(1));

   // Control registers: configuration, fade position and divider step count.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= lcm_pkg::MODE_RESET;
         length_ff     <= lcm_pkg::LENGTH_RESET;
         fade_index_ff <= '0;
         cnt_ff        <= '0;
      end else begin
         if (csr_write_en && csr_index == lcm_pkg::REG_SAMPLE_MODE) begin
            mode_ff <= csr_wdata[0];
         end
         if (csr_write_en && csr_index == lcm_pkg::REG_MIX_LENGTH) begin
            length_ff <= csr_wdata[lcm_pkg::LENGTH_W-1:0];
         end
         if (cmd.mix) fade_index_ff <= fade_index_in;
         cnt_ff <= cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n_ff      <= n_in;
         k_ff      <= k_in;
         last_ff   <= last_in;
         s_rise_ff <= s_rise_in;
         s_fall_ff <= s_fall_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      if (cmd.div_init) begin
         q_ff <= '0;
      end else if (cmd.div_step) begin
         q_ff <= q_in;
      end
      if (cmd.gain_save) begin
         if (cmd.div_fall) g_fall_ff <= q_in;
         else              g_rise_ff <= q_in;
      end
      if (cmd.mul_rise || cmd.mul_fall) prod_ff <= prod_in;
      if (cmd.mul_fall)   a_ff <= scale_product(prod_ff);
      if (cmd.scale_fall) b_ff <= scale_product(prod_ff);
      if (cmd.mix) begin
         mixed_ff    <= mixed_in;
         last_out_ff <= last_ff;
      end
   end

   assign rsp_mixed_sample = mixed_ff;
   assign rsp_last_of_fade = last_out_ff;

   // The captured index always lies below the captured length.
   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> ({1'b0, k_ff} < n_ff))
      else $error("fade index not clamped below the fade length");

   // A finished gain never exceeds unity.
   a_gain_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_rise |-> (g_rise_ff <= 9'd256) && (g_fall_ff <= 9'd256))
      else $error("gain above 256");

   // The last pair of a fade returns the index to zero.
   a_wrap_on_last: assert property (@(posedge clock) disable iff (reset)
      cmd.mix && last_ff |=> fade_index_ff == '0)
      else $error("fade index did not wrap after the last pair");

endmodule

@@ hw/rtl/linear_crossfade_mixer_top.sv @@
// Linear crossfade mixer, top level: controller plus datapath.
// Each transaction passes through two 9-step gain divisions, the shared multiplier
// and the mix stage, which waits while a stalled result still holds its register.
// The input is taken only while idle; a finished result waits in its own register.
// Reset (synchronous): fade index 0, sample_mode 1, mix_length 1, no result pending.
module linear_crossfade_mixer_top #(
   parameter int INDEX_WIDTH = lcm_pkg::INDEX_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [lcm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [lcm_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [lcm_pkg::SAMPLE_W-1:0]  req_rising_sample,
   input  logic signed [lcm_pkg::SAMPLE_W-1:0]  req_falling_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [lcm_pkg::SAMPLE_W-1:0]  rsp_mixed_sample,
   output logic                                 rsp_last_of_fade
);

   lcm_pkg::lcm_cmd_type    cmd;
   lcm_pkg::lcm_status_type status;

   // Sequencing of one transaction.
   lcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic and state.
   lcm_datapath #(
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_rising_sample  (req_rising_sample),
      .req_falling_sample (req_falling_sample),
      .rsp_mixed_sample   (rsp_mixed_sample),
      .rsp_last_of_fade   (rsp_last_of_fade),
      .cmd                (cmd),
      .status             (status)
   );

endmodule
